// ===== rtl/core/gsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_pkg
// Shared widths, types, register codes and the exp(-4x) table for the
// Gaussian spot fluctuation core.
// ----------------------------------------------------------------------------
package gsf_pkg;

    localparam int COORD_BITS    = 20;
    localparam int FRAC_BITS     = 16;
    localparam int AMP_BITS      = FRAC_BITS + 2;
    localparam int EXP_DEPTH     = 256;
    localparam int EXP_IDX_BITS  = $clog2(EXP_DEPTH);
    localparam int EXP_BITS      = FRAC_BITS + 1;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = DIFF_BITS + COORD_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;
    localparam int DIV_STAGES    = 4;
    localparam int DIV_STEP      = FRAC_BITS / DIV_STAGES;
    localparam int SCALE_BITS    = 18;
    localparam int CFG_W         = 3 * COORD_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int HP_BITS       = 60;

    localparam logic [SCALE_BITS-1:0] SCALE =
        SCALE_BITS'((64'd14996006613 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ulen_t;
    typedef logic signed [AMP_BITS-1:0]   amp_t;
    typedef logic        [FRAC_BITS-1:0]  quot_t;
    typedef logic        [EXP_BITS-1:0]   exp_t;
    typedef logic        [SCALE_BITS-1:0] fs_t;
    typedef exp_t exp_tab_t [0:EXP_DEPTH];

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_AXIS_LENGTHS,
        REG_AXIS_ONE,
        REG_AXIS_TWO,
        REG_AXIS_THREE,
        REG_LUND_ONE,
        REG_LUND_TWO,
        REG_LUND_THREE
    } cfg_reg_t;

    function automatic logic [63:0] mul_hp(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[HP_BITS+63:HP_BITS];
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] step;
        logic [63:0] v;
        x    = (64'd1 << (HP_BITS + 2)) / EXP_DEPTH;
        term = 64'd1 << HP_BITS;
        step = 64'd1 << HP_BITS;
        v    = 64'd1 << HP_BITS;
        for (int n = 1; n <= 24; n++)
        begin
            term = mul_hp(term, x) / 64'(n);
            if (n[0])
                step = step - term;
            else
                step = step + term;
        end
        for (int k = 0; k <= EXP_DEPTH; k++)
        begin
            tab[k] = EXP_BITS'((v + (64'd1 << (HP_BITS - FRAC_BITS - 1)))
                               >> (HP_BITS - FRAC_BITS));
            v = mul_hp(v, step);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// ===== rtl/core/gsf_proj.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_proj
// Offset, projection onto the three basis axes and box test (3 stages).
// ----------------------------------------------------------------------------
module gsf_proj (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  gsf_pkg::coord_t point [3],
    input  gsf_pkg::coord_t centre [3],
    input  gsf_pkg::amp_t   amp [3],
    input  gsf_pkg::coord_t basis [3][3],
    input  gsf_pkg::ulen_t  len [3],
    output logic            dn_valid,
    input  logic            dn_stall,
    output gsf_pkg::ulen_t  quot_num [3],
    output logic            in_box,
    output gsf_pkg::amp_t   amp_fwd [3]
);
    import gsf_pkg::*;

    localparam int STAGES = 3;

    logic v_reg [STAGES];
    logic en [STAGES+1];

    logic signed [DIFF_BITS-1:0] d_reg [3];
    logic signed [PROD_BITS-1:0] p_reg [3][3];
    ulen_t                       q_reg [3];
    logic                        ins_reg;
    amp_t                        amp_reg [STAGES][3];

    ulen_t q_next [3];
    logic  ins_next;

    always_comb
    begin
        en[STAGES] = !dn_stall;
        for (int k = STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign up_stall = !en[0];
    assign dn_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        logic signed [SUM_BITS-1:0] s;
        logic        [SUM_BITS-1:0] mag;
        ins_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            s = SUM_BITS'(p_reg[i][0]) + SUM_BITS'(p_reg[i][1]) + SUM_BITS'(p_reg[i][2]);
            mag = s[SUM_BITS-1] ? SUM_BITS'(-s) : SUM_BITS'(s);
            if (!(mag < SUM_BITS'({len[i], {FRAC_BITS{1'b0}}})))
                ins_next = 1'b0;
            q_next[i] = mag[FRAC_BITS +: COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                d_reg[j]      <= DIFF_BITS'(point[j]) - DIFF_BITS'(centre[j]);
                amp_reg[0][j] <= amp[j];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    p_reg[i][j] <= d_reg[j] * basis[i][j];
            amp_reg[1] <= amp_reg[0];
        end
        if (en[2])
        begin
            q_reg      <= q_next;
            ins_reg    <= ins_next;
            amp_reg[2] <= amp_reg[1];
        end
    end

    assign quot_num = q_reg;
    assign in_box   = ins_reg;
    assign amp_fwd  = amp_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/gsf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_div
// Three-lane restoring divider, (q << F) / L, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module gsf_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  gsf_pkg::ulen_t  quot_num [3],
    input  logic            in_box,
    input  gsf_pkg::amp_t   amp [3],
    input  gsf_pkg::ulen_t  len [3],
    output logic            dn_valid,
    input  logic            dn_stall,
    output gsf_pkg::quot_t  quot [3],
    output logic            inside_fwd,
    output gsf_pkg::amp_t   amp_fwd [3]
);
    import gsf_pkg::*;

    localparam int STAGES = DIV_STAGES;

    logic  v_reg [STAGES];
    logic  en [STAGES+1];
    ulen_t rem_reg [STAGES][3];
    quot_t quo_reg [STAGES][3];
    logic  ins_reg [STAGES];
    amp_t  amp_reg [STAGES][3];

    ulen_t rem_next [STAGES][3];
    quot_t quo_next [STAGES][3];

    always_comb
    begin
        en[STAGES] = !dn_stall;
        for (int k = STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign up_stall = !en[0];
    assign dn_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        ulen_t                 r;
        quot_t                 qq;
        logic [COORD_BITS:0]   t;
        for (int k = 0; k < STAGES; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (k == 0)
                begin
                    r  = quot_num[i];
                    qq = '0;
                end
                else
                begin
                    r  = rem_reg[k-1][i];
                    qq = quo_reg[k-1][i];
                end
                for (int s = 0; s < DIV_STEP; s++)
                begin
                    t = {r, 1'b0};
                    if (t >= {1'b0, len[i]})
                    begin
                        r  = COORD_BITS'(t - {1'b0, len[i]});
                        qq = {qq[FRAC_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        r  = t[COORD_BITS-1:0];
                        qq = {qq[FRAC_BITS-2:0], 1'b0};
                    end
                end
                rem_next[k][i] = r;
                quo_next[k][i] = qq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                if (k == 0)
                begin
                    ins_reg[0] <= in_box;
                    amp_reg[0] <= amp;
                end
                else
                begin
                    ins_reg[k] <= ins_reg[k-1];
                    amp_reg[k] <= amp_reg[k-1];
                end
            end
        end
    end

    assign quot       = quo_reg[STAGES-1];
    assign inside_fwd = ins_reg[STAGES-1];
    assign amp_fwd    = amp_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/gsf_exp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_exp
// Squared ratio, table exp(-4r) with interpolation, product of the three
// factors and the fixed amplitude scale (6 stages).
// ----------------------------------------------------------------------------
module gsf_exp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  gsf_pkg::quot_t  quot [3],
    input  logic            in_box,
    input  gsf_pkg::amp_t   amp [3],
    output logic            dn_valid,
    input  logic            dn_stall,
    output gsf_pkg::fs_t    fs,
    output logic            inside_fwd,
    output gsf_pkg::amp_t   amp_fwd [3]
);
    import gsf_pkg::*;

    localparam int STAGES = 6;

    logic  v_reg [STAGES];
    logic  en [STAGES+1];
    logic  ins_reg [STAGES];
    amp_t  amp_reg [STAGES][3];

    quot_t r_reg [3];
    exp_t  a_reg [3];
    exp_t  b_reg [3];
    quot_t fr_reg [3];
    exp_t  e_reg [3];
    exp_t  f1_reg;
    exp_t  e2_reg;
    exp_t  f2_reg;
    fs_t   fs_reg;

    logic [2*FRAC_BITS-1:0]         sq_next [3];
    logic [EXP_IDX_BITS:0]          idx_next [3];
    exp_t                           e_next [3];
    logic [2*EXP_BITS-1:0]          f1_prod;
    logic [2*EXP_BITS-1:0]          f2_prod;
    logic [EXP_BITS+SCALE_BITS-1:0] fs_prod;

    always_comb
    begin
        en[STAGES] = !dn_stall;
        for (int k = STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign up_stall = !en[0];
    assign dn_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        logic [EXP_BITS+FRAC_BITS-1:0] m;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i]  = (2*FRAC_BITS)'(quot[i]) * (2*FRAC_BITS)'(quot[i]);
            idx_next[i] = {1'b0, r_reg[i][FRAC_BITS-1 -: EXP_IDX_BITS]};
            m           = (EXP_BITS+FRAC_BITS)'(a_reg[i] - b_reg[i])
                          * (EXP_BITS+FRAC_BITS)'(fr_reg[i]);
            e_next[i]   = a_reg[i] - m[FRAC_BITS +: EXP_BITS];
        end
        f1_prod = (2*EXP_BITS)'(e_reg[0]) * (2*EXP_BITS)'(e_reg[1]);
        f2_prod = (2*EXP_BITS)'(f1_reg) * (2*EXP_BITS)'(e2_reg);
        fs_prod = (EXP_BITS+SCALE_BITS)'(f2_reg) * (EXP_BITS+SCALE_BITS)'(SCALE);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (en[k])
            begin
                if (k == 0)
                begin
                    ins_reg[0] <= in_box;
                    amp_reg[0] <= amp;
                end
                else
                begin
                    ins_reg[k] <= ins_reg[k-1];
                    amp_reg[k] <= amp_reg[k-1];
                end
            end
        end
        if (en[0])
            for (int i = 0; i < 3; i++)
                r_reg[i] <= sq_next[i][FRAC_BITS +: FRAC_BITS];
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i]  <= EXP_TAB[idx_next[i]];
                b_reg[i]  <= EXP_TAB[idx_next[i] + 1'b1];
                fr_reg[i] <= {r_reg[i][FRAC_BITS-EXP_IDX_BITS-1:0], {EXP_IDX_BITS{1'b0}}};
            end
        end
        if (en[2])
            e_reg <= e_next;
        if (en[3])
        begin
            f1_reg <= f1_prod[FRAC_BITS +: EXP_BITS];
            e2_reg <= e_reg[2];
        end
        if (en[4])
            f2_reg <= f2_prod[FRAC_BITS +: EXP_BITS];
        if (en[5])
            fs_reg <= fs_prod[FRAC_BITS +: SCALE_BITS];
    end

    assign fs         = fs_reg;
    assign inside_fwd = ins_reg[STAGES-1];
    assign amp_fwd    = amp_reg[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/gsf_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsf_mix
// Scaled amplitude, Lund tensor product, truncating shift and clipping
// (3 stages, the last is the output register).
// ----------------------------------------------------------------------------
module gsf_mix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  gsf_pkg::fs_t    fs,
    input  logic            in_box,
    input  gsf_pkg::amp_t   amp [3],
    input  gsf_pkg::coord_t lund [3][3],
    output logic            dn_valid,
    input  logic            dn_stall,
    output gsf_pkg::coord_t vel [3],
    output logic            inside_res,
    output logic            saturated
);
    import gsf_pkg::*;

    localparam int STAGES  = 3;
    localparam int WP_BITS = AMP_BITS + SCALE_BITS + 1;
    localparam int LP_BITS = 2 * COORD_BITS;
    localparam int AC_BITS = LP_BITS + 2;
    localparam int SH_BITS = AC_BITS - FRAC_BITS;
    localparam logic signed [SH_BITS-1:0] VEL_HI = SH_BITS'(2**(COORD_BITS-1) - 1);
    localparam logic signed [SH_BITS-1:0] VEL_LO = -VEL_HI - SH_BITS'(1);

    logic   v_reg [STAGES];
    logic   en [STAGES+1];
    logic   ins_reg [STAGES];
    coord_t w_reg [3];
    logic signed [LP_BITS-1:0] lp_reg [3][3];
    coord_t vel_reg [3];
    logic   sat_reg;

    coord_t w_next [3];
    coord_t vel_next [3];
    logic   sat_next;

    always_comb
    begin
        en[STAGES] = !dn_stall;
        for (int k = STAGES - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign up_stall = !en[0];
    assign dn_valid = v_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < STAGES; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        logic signed [WP_BITS-1:0] wp;
        logic signed [AC_BITS-1:0] acc;
        logic signed [SH_BITS-1:0] v;
        for (int j = 0; j < 3; j++)
        begin
            wp        = WP_BITS'(amp[j]) * $signed({1'b0, fs});
            w_next[j] = wp[FRAC_BITS +: COORD_BITS];
        end
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = AC_BITS'(lp_reg[i][0]) + AC_BITS'(lp_reg[i][1]) + AC_BITS'(lp_reg[i][2]);
            v   = acc[AC_BITS-1:FRAC_BITS];
            if (v > VEL_HI)
            begin
                v        = VEL_HI;
                sat_next = 1'b1;
            end
            else if (v < VEL_LO)
            begin
                v        = VEL_LO;
                sat_next = 1'b1;
            end
            vel_next[i] = ins_reg[1] ? v[COORD_BITS-1:0] : '0;
        end
        if (!ins_reg[1])
            sat_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg      <= w_next;
            ins_reg[0] <= in_box;
        end
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    lp_reg[i][j] <= lund[i][j] * w_reg[j];
            ins_reg[1] <= ins_reg[0];
        end
        if (en[2])
        begin
            vel_reg    <= vel_next;
            sat_reg    <= sat_next;
            ins_reg[2] <= ins_reg[1];
        end
    end

    assign vel        = vel_reg;
    assign inside_res = ins_reg[STAGES-1];
    assign saturated  = sat_reg;

endmodule
`default_nettype wire

// ===== rtl/core/gaussian_spot_fluctuation_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_spot_fluctuation_core
// Gaussian eddy shape function: velocity fluctuation of one point from one
// eddy, projected on configured axes and mixed by the Lund tensor.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall carries one request: point, eddy centre
//    and amplitude. Output channel out_valid/out_stall returns one result per
//    request, in order: velocity, inside flag and clip flag.
//  - Configuration: write cfg_data to register cfg_index while cfg_we is high,
//    only with no requests in flight. Lengths, three axes, three Lund rows.
//  - Pipeline order: projection, divider, exponential, mixing.
//  - Throughput one request per cycle while out_stall is low; the three
//    divider lanes run in parallel, a few quotient bits per stage.
//  - Every stage holds its own valid bit, so empty stages fill while the
//    output is stalled; in_stall rises only when all stages are full.
//  - Reset clears all valid bits and the configuration registers to zero.
//  - A point outside the eddy box gives zero velocity and zero flags.
// ----------------------------------------------------------------------------
module gaussian_spot_fluctuation_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gsf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [gsf_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  gsf_pkg::coord_t                      point_x,
    input  gsf_pkg::coord_t                      point_y,
    input  gsf_pkg::coord_t                      point_z,
    input  gsf_pkg::coord_t                      centre_x,
    input  gsf_pkg::coord_t                      centre_y,
    input  gsf_pkg::coord_t                      centre_z,
    input  gsf_pkg::amp_t                        amp_x,
    input  gsf_pkg::amp_t                        amp_y,
    input  gsf_pkg::amp_t                        amp_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output gsf_pkg::coord_t                      vel_x,
    output gsf_pkg::coord_t                      vel_y,
    output gsf_pkg::coord_t                      vel_z,
    output logic                                 inside_res,
    output logic                                 saturated
);
    import gsf_pkg::*;

    logic [CFG_W-1:0] len_reg;
    logic [CFG_W-1:0] axis_reg [3];
    logic [CFG_W-1:0] lund_reg [3];

    coord_t point [3];
    coord_t centre [3];
    amp_t   amp [3];
    coord_t basis [3][3];
    coord_t lund [3][3];
    ulen_t  len [3];
    coord_t vel [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                axis_reg[i] <= '0;
                lund_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AXIS_LENGTHS: len_reg     <= cfg_data;
                REG_AXIS_ONE:     axis_reg[0] <= cfg_data;
                REG_AXIS_TWO:     axis_reg[1] <= cfg_data;
                REG_AXIS_THREE:   axis_reg[2] <= cfg_data;
                REG_LUND_ONE:     lund_reg[0] <= cfg_data;
                REG_LUND_TWO:     lund_reg[1] <= cfg_data;
                REG_LUND_THREE:   lund_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        point  = '{point_x, point_y, point_z};
        centre = '{centre_x, centre_y, centre_z};
        amp    = '{amp_x, amp_y, amp_z};
        for (int i = 0; i < 3; i++)
        begin
            len[i] = len_reg[i*COORD_BITS +: COORD_BITS];
            for (int j = 0; j < 3; j++)
            begin
                basis[i][j] = axis_reg[i][j*COORD_BITS +: COORD_BITS];
                lund[i][j]  = lund_reg[i][j*COORD_BITS +: COORD_BITS];
            end
        end
    end

    logic   pj_valid;
    logic   pj_stall;
    ulen_t  pj_q [3];
    logic   pj_ins;
    amp_t   pj_amp [3];

    logic   dv_valid;
    logic   dv_stall;
    quot_t  dv_t [3];
    logic   dv_ins;
    amp_t   dv_amp [3];

    logic   ex_valid;
    logic   ex_stall;
    fs_t    ex_fs;
    logic   ex_ins;
    amp_t   ex_amp [3];

    gsf_proj u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .point    (point),
        .centre   (centre),
        .amp      (amp),
        .basis    (basis),
        .len      (len),
        .dn_valid (pj_valid),
        .dn_stall (pj_stall),
        .quot_num (pj_q),
        .in_box   (pj_ins),
        .amp_fwd  (pj_amp)
    );

    gsf_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (pj_valid),
        .up_stall   (pj_stall),
        .quot_num   (pj_q),
        .in_box     (pj_ins),
        .amp        (pj_amp),
        .len        (len),
        .dn_valid   (dv_valid),
        .dn_stall   (dv_stall),
        .quot       (dv_t),
        .inside_fwd (dv_ins),
        .amp_fwd    (dv_amp)
    );

    gsf_exp u_exp (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (dv_valid),
        .up_stall   (dv_stall),
        .quot       (dv_t),
        .in_box     (dv_ins),
        .amp        (dv_amp),
        .dn_valid   (ex_valid),
        .dn_stall   (ex_stall),
        .fs         (ex_fs),
        .inside_fwd (ex_ins),
        .amp_fwd    (ex_amp)
    );

    gsf_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (ex_valid),
        .up_stall   (ex_stall),
        .fs         (ex_fs),
        .in_box     (ex_ins),
        .amp        (ex_amp),
        .lund       (lund),
        .dn_valid   (out_valid),
        .dn_stall   (out_stall),
        .vel        (vel),
        .inside_res (inside_res),
        .saturated  (saturated)
    );

    assign vel_x = vel[0];
    assign vel_y = vel[1];
    assign vel_z = vel[2];

`ifndef NO_ASSERTIONS
    localparam coord_t VEL_MAX = coord_t'(2**(COORD_BITS-1) - 1);
    localparam coord_t VEL_MIN = ~VEL_MAX;

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> vel_x == '0 && vel_y == '0 && vel_z == '0 && !saturated)
        else $error("outside result not zero");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            vel_x == VEL_MAX || vel_x == VEL_MIN || vel_y == VEL_MAX ||
            vel_y == VEL_MIN || vel_z == VEL_MAX || vel_z == VEL_MIN)
        else $error("clip flag without clipped component");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/gaussian_spot_fluctuation_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_spot_fluctuation_core_test
// Drives point and eddy requests through the Gaussian spot fluctuation core
// under several register settings. Both sides idle at random. Each result is
// checked against a bit-exact fixed-point prediction of the eddy shape.
// ----------------------------------------------------------------------------
module gaussian_spot_fluctuation_core_test;

    import gsf_pkg::*;

    typedef struct {
        coord_t vx;
        coord_t vy;
        coord_t vz;
        logic   in_box;
        logic   clip;
    } velocity_t;

    class eddy_scoreboard;
        logic [CFG_W-1:0] lengths;
        logic [CFG_W-1:0] axes [3];
        logic [CFG_W-1:0] lund [3];
        longint           exp_lut [0:EXP_DEPTH];
        velocity_t        pending [$];
        int               errors;

        function new();
            lengths = '0;
            for (int i = 0; i < 3; i++)
            begin
                axes[i] = '0;
                lund[i] = '0;
            end
            errors = 0;
            fill_exp_lut();
        endfunction

        function logic [63:0] fix60_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        endfunction

        function void fill_exp_lut();
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] ratio;
            logic [63:0] acc;
            x     = 64'd1 << 54;
            term  = 64'd1 << 60;
            ratio = 64'd1 << 60;
            acc   = 64'd1 << 60;
            for (int n = 1; n <= 24; n++)
            begin
                term = fix60_mul(term, x) / n;
                if (n % 2 == 1)
                    ratio = ratio - term;
                else
                    ratio = ratio + term;
            end
            for (int k = 0; k <= EXP_DEPTH; k++)
            begin
                exp_lut[k] = longint'((acc + (64'd1 << 43)) >> 44);
                acc = fix60_mul(acc, ratio);
            end
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_AXIS_LENGTHS: lengths = val;
                REG_AXIS_ONE:     axes[0] = val;
                REG_AXIS_TWO:     axes[1] = val;
                REG_AXIS_THREE:   axes[2] = val;
                REG_LUND_ONE:     lund[0] = val;
                REG_LUND_TWO:     lund[1] = val;
                REG_LUND_THREE:   lund[2] = val;
                default:          ;
            endcase
        endfunction

        function longint decay(longint r);
            longint x;
            longint idx;
            longint fr;
            x   = r * EXP_DEPTH;
            idx = x >> FRAC_BITS;
            fr  = x & ((64'd1 << FRAC_BITS) - 1);
            if (idx >= EXP_DEPTH)
                return exp_lut[EXP_DEPTH];
            return exp_lut[idx] - (((exp_lut[idx] - exp_lut[idx + 1]) * fr) >> FRAC_BITS);
        endfunction

        function void note_request(coord_t p[3], coord_t c[3], amp_t a[3]);
            velocity_t res;
            longint    d [3];
            longint    w [3];
            longint    s, mag, len, q, t, r, f, fs, acc, v, scale;
            coord_t    comp;
            res   = '{default: '0};
            f     = 64'd1 << FRAC_BITS;
            scale = (64'd14996006613 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
            for (int i = 0; i < 3; i++)
                d[i] = longint'(p[i]) - longint'(c[i]);
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                begin
                    comp = axes[i][j*COORD_BITS +: COORD_BITS];
                    s += d[j] * longint'(comp);
                end
                mag = (s < 0) ? -s : s;
                len = longint'(lengths[i*COORD_BITS +: COORD_BITS]);
                if (mag >= (len << FRAC_BITS))
                begin
                    pending.push_back(res);
                    return;
                end
                q = mag >> FRAC_BITS;
                t = (q << FRAC_BITS) / len;
                r = (t * t) >> FRAC_BITS;
                f = (f * decay(r)) >> FRAC_BITS;
            end
            fs = (f * scale) >> FRAC_BITS;
            for (int j = 0; j < 3; j++)
                w[j] = (longint'(a[j]) * fs) >>> FRAC_BITS;
            res.in_box = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                begin
                    comp = lund[i][j*COORD_BITS +: COORD_BITS];
                    acc += longint'(comp) * w[j];
                end
                v = acc >>> FRAC_BITS;
                if (v > 524287)
                begin
                    v = 524287;
                    res.clip = 1'b1;
                end
                if (v < -524288)
                begin
                    v = -524288;
                    res.clip = 1'b1;
                end
                case (i)
                    0: res.vx = coord_t'(v);
                    1: res.vy = coord_t'(v);
                    default: res.vz = coord_t'(v);
                endcase
            end
            pending.push_back(res);
        endfunction

        function void check_result(velocity_t got);
            velocity_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.vx !== exp_r.vx)
            begin
                $error("vel_x expected %0d got %0d", exp_r.vx, got.vx);
                errors++;
            end
            if (got.vy !== exp_r.vy)
            begin
                $error("vel_y expected %0d got %0d", exp_r.vy, got.vy);
                errors++;
            end
            if (got.vz !== exp_r.vz)
            begin
                $error("vel_z expected %0d got %0d", exp_r.vz, got.vz);
                errors++;
            end
            if (got.in_box !== exp_r.in_box)
            begin
                $error("inside_res expected %0b got %0b", exp_r.in_box, got.in_box);
                errors++;
            end
            if (got.clip !== exp_r.clip)
            begin
                $error("saturated expected %0b got %0b", exp_r.clip, got.clip);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    coord_t                  point_x, point_y, point_z;
    coord_t                  centre_x, centre_y, centre_z;
    amp_t                    amp_x, amp_y, amp_z;
    logic                    out_valid;
    logic                    out_stall;
    coord_t                  vel_x, vel_y, vel_z;
    logic                    inside_res;
    logic                    saturated;

    eddy_scoreboard sb;
    bit             calm;

    gaussian_spot_fluctuation_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .centre_z   (centre_z),
        .amp_x      (amp_x),
        .amp_y      (amp_y),
        .amp_z      (amp_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .inside_res (inside_res),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("gaussian_spot_fluctuation_core test failed");
        $finish;
    end

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stall
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = idle_len();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        velocity_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.vx     = vel_x;
                got.vy     = vel_y;
                got.vz     = vel_z;
                got.in_box = inside_res;
                got.clip   = saturated;
                sb.check_result(got);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] len, logic [CFG_W-1:0] e1,
                                logic [CFG_W-1:0] e2, logic [CFG_W-1:0] e3,
                                logic [CFG_W-1:0] l1, logic [CFG_W-1:0] l2,
                                logic [CFG_W-1:0] l3);
        write_reg(REG_AXIS_LENGTHS, len);
        write_reg(REG_AXIS_ONE, e1);
        write_reg(REG_AXIS_TWO, e2);
        write_reg(REG_AXIS_THREE, e3);
        write_reg(REG_LUND_ONE, l1);
        write_reg(REG_LUND_TWO, l2);
        write_reg(REG_LUND_THREE, l3);
    endtask

    task automatic send_request(coord_t p[3], coord_t c[3], amp_t a[3]);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        point_x  <= p[0];
        point_y  <= p[1];
        point_z  <= p[2];
        centre_x <= c[0];
        centre_y <= c[1];
        centre_z <= c[2];
        amp_x    <= a[0];
        amp_y    <= a[1];
        amp_z    <= a[2];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(p, c, a);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic coord_t near_unit();
        return coord_t'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic logic [CFG_W-1:0] pack3(coord_t a, coord_t b, coord_t c);
        return {c, b, a};
    endfunction

    function automatic amp_t rand_amp();
        return amp_t'(int'($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic random_requests(int count);
        coord_t p [3];
        coord_t c [3];
        amp_t   a [3];
        int     span;
        for (int n = 0; n < count; n++)
        begin
            span = ($urandom_range(0, 3) == 0) ? 1 << 18 : 3 << 16;
            for (int i = 0; i < 3; i++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    p[i] = coord_t'($urandom);
                    c[i] = coord_t'($urandom);
                end
                else
                begin
                    c[i] = coord_t'(int'($urandom_range(0, 2 * (524287 - span)))
                                    - (524287 - span));
                    p[i] = coord_t'(int'(c[i]) + int'($urandom_range(0, 2 * span)) - span);
                end
                a[i] = rand_amp();
            end
            send_request(p, c, a);
        end
    endtask

    task automatic directed_requests();
        coord_t p [3];
        coord_t c [3];
        amp_t   a [3];
        int     offs [8] = '{0, 131071, 131072, -131071, -131072, 65536, -1, 1};
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = coord_t'(1000 * i);
                p[i] = coord_t'(1000 * i + ((i == k % 3) ? offs[k] : 0));
                a[i] = (k % 2 == 0) ? amp_t'(65536) : amp_t'(-65536);
            end
            send_request(p, c, a);
        end
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p[i] = (k[0]) ? coord_t'(524287) : coord_t'(-524288);
                c[i] = (k[1]) ? coord_t'(524287) : coord_t'(-524288);
                a[i] = amp_t'(0);
            end
            send_request(p, c, a);
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c[i] = coord_t'(-7);
                p[i] = coord_t'(-7 + 30000 * k);
                a[i] = amp_t'((i == k) ? 65536 : -65536);
            end
            send_request(p, c, a);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] unit_len;
        logic [CFG_W-1:0] ex, ey, ez;
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        {point_x, point_y, point_z, centre_x, centre_y, centre_z} = '0;
        {amp_x, amp_y, amp_z} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero lengths out of reset: nothing inside
        random_requests(30);
        drain();

        unit_len = pack3(coord_t'(131072), coord_t'(131072), coord_t'(131072));
        ex = pack3(coord_t'(65536), coord_t'(0), coord_t'(0));
        ey = pack3(coord_t'(0), coord_t'(65536), coord_t'(0));
        ez = pack3(coord_t'(0), coord_t'(0), coord_t'(65536));
        program_regs(unit_len, ex, ey, ez, ex, ey, ez);
        directed_requests();
        random_requests(150);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            calm = (ph == 2);
            case (ph)
                0: program_regs({CFG_W{1'b1}}, ex, ey, ez,
                                pack3(coord_t'(524287), coord_t'(524287), coord_t'(524287)),
                                pack3(coord_t'(-524288), coord_t'(-524288), coord_t'(-524288)),
                                pack3(coord_t'(524287), coord_t'(-524288), coord_t'(0)));
                1: program_regs(pack3(coord_t'(32768), coord_t'(262144), coord_t'(1)),
                                pack3(coord_t'(-65536), coord_t'(0), coord_t'(0)),
                                pack3(coord_t'(0), coord_t'(-65536), coord_t'(0)),
                                pack3(coord_t'(46341), coord_t'(0), coord_t'(-46341)),
                                ez, ex, ey);
                5: program_regs(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                                CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                                CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
                                CFG_W'({$urandom, $urandom}));
                default: program_regs(
                                pack3(coord_t'($urandom_range(16384, 262144)),
                                      coord_t'($urandom_range(16384, 262144)),
                                      coord_t'($urandom_range(16384, 262144))),
                                pack3(near_unit(), near_unit(), near_unit()),
                                pack3(near_unit(), near_unit(), near_unit()),
                                pack3(near_unit(), near_unit(), near_unit()),
                                pack3(near_unit(), near_unit(), near_unit()),
                                pack3(near_unit(), near_unit(), near_unit()),
                                pack3(coord_t'($urandom), coord_t'($urandom),
                                      coord_t'($urandom)));
            endcase
            random_requests(165);
            drain();
        end

        if (sb.errors == 0)
            $display("gaussian_spot_fluctuation_core test passed");
        else
            $display("gaussian_spot_fluctuation_core test failed");
        $finish;
    end

endmodule

// ===== gaussian_spot_fluctuation_core.f =====
rtl/core/gsf_pkg.sv
rtl/core/gsf_proj.sv
rtl/core/gsf_div.sv
rtl/core/gsf_exp.sv
rtl/core/gsf_mix.sv
rtl/core/gaussian_spot_fluctuation_core.sv
tb/sv/gaussian_spot_fluctuation_core_test.sv
